>>> hdl/rdqa_pkg.sv
// Package with the shared constants, codes and word types of the record deque with average.
`default_nettype none

package rdqa_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 3;
    localparam int ID_W    = 30;
    localparam int GRADE_W = 7;
    localparam int STAT_W  = 2;
    localparam int SUM_W   = 11;
    localparam int FRAC_W  = 8;
    localparam int DIVD_W  = SUM_W + FRAC_W;
    localparam int AVG_W   = 15;
    localparam int QDEPTH  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_AVERAGE    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ID_W-1:0]    student_id;
        logic [GRADE_W-1:0] grade;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [GRADE_W-1:0] front_grade;
        logic [GRADE_W-1:0] back_grade;
        logic [CNT_W-1:0]   entry_count;
        logic [AVG_W-1:0]   average_grade;
    } result_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic               at_front;
        logic               check;
        logic               average;
        logic [ID_W-1:0]    student_id;
        logic [GRADE_W-1:0] grade;
    } op_word_t;

    typedef struct packed {
        logic     valid;
        op_word_t word;
    } op_link_t;

endpackage

`default_nettype wire

>>> hdl/rdqa_div.sv
// Restoring divider that gives the fixed point average one quotient bit per cycle.
`default_nettype none

module rdqa_div
    import rdqa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              div_start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output logic                   div_done,
    output logic [DIVD_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    rem_sh;
    logic              fits;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIVD_W-1]};
        fits      = rem_sh >= {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (div_start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DIVD_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next  = {quo_reg[DIVD_W-2:0], fits};
            rem_next  = fits ? CNT_W'(rem_sh - {1'b0, dsr_reg}) : CNT_W'(rem_sh);
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (div_start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign div_done = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/rdqa_front.sv
// Front end: accepts command words, decodes them and holds them in a short queue.
`default_nettype none

module rdqa_front
    import rdqa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    input  wire logic     take,
    output op_link_t      link
);

    localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QF_W = $clog2(QDEPTH + 1);

    op_word_t          queue_mem [QDEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QF_W-1:0]   fill_reg, fill_next;
    op_word_t          decoded;
    logic              accept;
    logic              pull;

    always_comb
    begin
        decoded            = '0;
        decoded.student_id = request.student_id;
        decoded.grade      = request.grade;
        decoded.at_front   = (request.command == CMD_PUSH_FRONT) ||
                             (request.command == CMD_POP_FRONT);
        unique case (request.command) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: decoded.push    = 1'b1;
            CMD_POP_FRONT, CMD_POP_BACK:   decoded.pop     = 1'b1;
            CMD_PEEK:                      decoded.check   = 1'b1;
            CMD_AVERAGE:                   decoded.average = 1'b1;
            default:                       decoded.push    = 1'b0;
        endcase
    end

    assign busy   = fill_reg == QF_W'(QDEPTH);
    assign accept = start && !busy;
    assign pull   = take && (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !pull)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pull && !accept)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_mem[wr_ptr_reg] <= decoded;
        end
    end

    assign link.valid = fill_reg != '0;
    assign link.word  = queue_mem[rd_ptr_reg];

endmodule

`default_nettype wire

>>> hdl/rdqa_back.sv
// Back end: ring store, head and count, grade sum, average sequencing and result register.
`default_nettype none

module rdqa_back
    import rdqa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire op_link_t link,
    output logic          take,
    output logic          done,
    output result_t       result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [GRADE_W-1:0] grade_mem [DEPTH];
    logic [ID_W-1:0]    id_mem    [DEPTH];

    logic [2:0]          state_reg, state_next;
    op_word_t            word_reg;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [GRADE_W-1:0]  rd_front_reg, rd_back_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic                done_reg;
    result_t             result_reg;

    logic                full;
    logic                empty;
    logic [IDX_W-1:0]    head_dec;
    logic [IDX_W-1:0]    head_inc;
    logic [IDX_W-1:0]    tail_slot;
    logic [IDX_W-1:0]    back_slot;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_slot;
    logic                div_start;
    logic                div_done;
    logic [DIVD_W-1:0]   quotient;

    function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W:0] slot);
        logic [IDX_W:0] lim;
        begin
            lim = (IDX_W + 1)'(DEPTH);
            ring_wrap = (slot >= lim) ? IDX_W'(slot - lim) : IDX_W'(slot);
        end
    endfunction

    assign full      = count_reg >= CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign head_dec  = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc  = ring_wrap((IDX_W + 1)'(head_reg) + (IDX_W + 1)'(1));
    assign tail_slot = ring_wrap((IDX_W + 1)'(head_reg) + (IDX_W + 1)'(count_reg));
    assign back_slot = empty ? head_reg :
                       ring_wrap((IDX_W + 1)'(head_reg) + (IDX_W + 1)'(count_reg) -
                                 (IDX_W + 1)'(1));

    assign take      = (state_reg == S_IDLE) && link.valid;
    assign div_start = (state_reg == S_READ) && word_reg.average && !empty;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_slot     = tail_slot;
        unique case (state_reg)
            S_IDLE:
            begin
                if (link.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                if (word_reg.push)
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_slot    = word_reg.at_front ? head_dec : tail_slot;
                        head_next  = word_reg.at_front ? head_dec : head_reg;
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(word_reg.grade);
                    end
                end
                else if (word_reg.pop)
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        head_next  = word_reg.at_front ? head_inc : head_reg;
                        count_next = count_reg - 1'b1;
                        sum_next   = sum_reg - SUM_W'(word_reg.at_front ? rd_front_reg
                                                                        : rd_back_reg);
                    end
                end
                else if ((word_reg.check || word_reg.average) && empty)
                begin
                    status_next = ST_EMPTY;
                end
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = div_start ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            done_reg  <= state_reg == S_FIN;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (take)
        begin
            word_reg <= link.word;
        end
        if (wr_en)
        begin
            grade_mem[wr_slot] <= word_reg.grade;
            id_mem[wr_slot]    <= word_reg.student_id;
        end
        if (state_reg == S_READ)
        begin
            rd_front_reg <= grade_mem[head_reg];
            rd_back_reg  <= grade_mem[back_slot];
        end
        if (div_done)
        begin
            avg_reg <= quotient[AVG_W-1:0];
        end
        if (state_reg == S_FIN)
        begin
            result_reg.status        <= status_reg;
            result_reg.front_grade   <= empty ? '0 : rd_front_reg;
            result_reg.back_grade    <= empty ? '0 : rd_back_reg;
            result_reg.entry_count   <= count_reg;
            result_reg.average_grade <= (word_reg.average && !empty) ? avg_reg : '0;
        end
    end

    rdqa_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .div_start (div_start),
        .dividend  ({sum_reg, FRAC_W'(0)}),
        .divisor   (count_reg),
        .div_done  (div_done),
        .quotient  (quotient)
    );

    assign done   = done_reg;
    assign result = result_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("grade sum nonzero with empty store");

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_FIN))
        else $error("result strobe without finish step");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (count_reg != '0))
        else $error("divide started with zero count");

endmodule

`default_nettype wire

>>> hdl/record_deque_with_average_unit.sv
// Top level of the record deque with average: front queue and back execution unit.
// A word is taken when start is high and busy is low; a two-word queue lets the next words
// in while the back end works. Each word gives one result, shown on result for one cycle with
// done high; the receiver cannot stall it. Push, pop, peek and unknown commands pass through
// these steps in the back end: take, execute, registered store read and result register.
// The average command on a non-empty store adds the restoring divider between the read and
// the result, one quotient bit per cycle over 19 bits. The back end handles one word at a
// time and takes no new word from the queue until it has given the result of the last.
`default_nettype none

module record_deque_with_average_unit
    import rdqa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    op_link_t link;
    logic     take;

    rdqa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .take    (take),
        .link    (link)
    );

    rdqa_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .link   (link),
        .take   (take),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
